>>> sv/sset_pkg.sv
// ============================================================================
// sset_pkg
// Shared types and codes for the sorted set block: command and status codes
// and the packed item structs for the input and result channels.
// ============================================================================
package sset_pkg;

    // Operation codes carried in the command field
    typedef enum logic [1:0] {
        CMD_SEARCH = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DELETE = 2'd2
    } cmd_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_DUPLICATE = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_W = 5;

    // One input item
    typedef struct packed {
        logic [1:0]                command;
        logic signed [VALUE_W-1:0] value;
    } in_item_t;

    // One result item
    typedef struct packed {
        logic               found;
        status_t            status;
        logic [COUNT_W-1:0] count;
    } out_item_t;

    // Shift request broadcast to every cell
    typedef struct packed {
        logic ins;
        logic del;
    } shift_t;

endpackage

>>> sv/sset_cell.sv
// ============================================================================
// sset_cell
// One slot of the sorted store. Compares its entry with the operand and
// takes its next entry from itself, the operand or a neighbor.
// ============================================================================
module sset_cell
    import sset_pkg::*;
(
    input  logic                      clk,
    input  logic                      slot_valid,
    input  logic signed [VALUE_W-1:0] value,
    input  shift_t                    shift,
    input  logic                      before_lt,
    input  logic signed [VALUE_W-1:0] prev_entry,
    input  logic signed [VALUE_W-1:0] next_entry,
    output logic                      lt,
    output logic                      eq,
    output logic signed [VALUE_W-1:0] entry
);

    logic signed [VALUE_W-1:0] entry_reg;
    logic signed [VALUE_W-1:0] entry_next;

    // Compare the stored entry with the operand
    assign lt    = slot_valid && (entry_reg < value);
    assign eq    = slot_valid && (entry_reg == value);
    assign entry = entry_reg;

    // Keep slots below the insert/delete point, shift the rest
    always_comb
    begin
        entry_next = entry_reg;
        if (shift.ins && !lt)
        begin
            entry_next = before_lt ? value : prev_entry;
        end
        else if (shift.del && !lt)
        begin
            entry_next = next_entry;
        end
    end

    // Hold the entry; no reset, slots are read only below the count
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

>>> sv/sset_resolve.sv
// ============================================================================
// sset_resolve
// Reduces the per-cell match flags to the result of one operation and
// decides whether the cells shift and how the entry count moves.
// ============================================================================
module sset_resolve
    import sset_pkg::*;
#(
    parameter int unsigned CAPACITY = 16,
    parameter int unsigned CW       = $clog2(CAPACITY + 1)
)
(
    input  logic                fire,
    input  logic [1:0]          command,
    input  logic [CAPACITY-1:0] eq,
    input  logic [CW-1:0]       count,
    output logic                hit,
    output status_t             status,
    output shift_t              shift,
    output logic [CW-1:0]       count_next
);

    logic full;

    assign hit  = |eq;
    assign full = (count == CW'(CAPACITY));

    // Pick status and shift direction per command
    always_comb
    begin
        status     = hit ? ST_DONE : ST_NOT_FOUND;
        shift      = '0;
        count_next = count;
        case (command)
            CMD_INSERT:
            begin
                if (hit)
                begin
                    status = ST_DUPLICATE;
                end
                else if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    status     = ST_DONE;
                    shift.ins  = fire;
                    count_next = fire ? count + CW'(1) : count;
                end
            end
            CMD_DELETE:
            begin
                if (hit)
                begin
                    status     = ST_DONE;
                    shift.del  = fire;
                    count_next = fire ? count - CW'(1) : count;
                end
                else
                begin
                    status = ST_NOT_FOUND;
                end
            end
            default:
            begin
                status = hit ? ST_DONE : ST_NOT_FOUND;
            end
        endcase
    end

endmodule

>>> sv/sorted_set_insert_search_delete_top.sv
// ============================================================================
// Sorted set insert / search / delete
// Bounded ascending set of distinct signed 32-bit values with search,
// insert and delete operations, one result per item.
// ============================================================================
// Each accepted item sits in an input register; once the result register
// can take it, every slot compares against it in parallel, the slots shift
// in one step, and the result is written to an output register. One item
// completes per cycle while the receiver does not hold off the output; the
// rate is set by the single compare-and-shift pass over the slot row. Entries
// live in CAPACITY slot registers and only slots below the entry count are
// read, so the store needs no clearing after reset. The count field reports
// the entry count in its low five bits.
module sorted_set_insert_search_delete_top
    import sset_pkg::*;
#(
    parameter int unsigned CAPACITY = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);

    logic                      in_valid_reg;
    in_item_t                  in_item_reg;
    logic                      out_valid_reg;
    out_item_t                 out_item_reg;
    out_item_t                 out_item_next;
    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             count_next;
    logic                      fire;
    logic                      hit;
    status_t                   status;
    shift_t                    shift;
    logic [CAPACITY-1:0]       lt;
    logic [CAPACITY-1:0]       eq;
    logic signed [VALUE_W-1:0] entry [CAPACITY];
    logic [CW+COUNT_W-1:0]     count_wide;

    // Process the held item when the result register can take it
    assign fire      = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || fire;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Slot row
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        localparam logic [CW-1:0] IDX = CW'(i);
        localparam int unsigned   PRV = (i == 0) ? 0 : i - 1;
        localparam int unsigned   NXT = (i == CAPACITY - 1) ? i : i + 1;

        logic before_lt;

        if (i == 0)
        begin : g_first
            assign before_lt = 1'b1;
        end
        else
        begin : g_rest
            assign before_lt = lt[PRV];
        end

        sset_cell u_cell (
            .clk        (clk),
            .slot_valid (IDX < count_reg),
            .value      (in_item_reg.value),
            .shift      (shift),
            .before_lt  (before_lt),
            .prev_entry (entry[PRV]),
            .next_entry (entry[NXT]),
            .lt         (lt[i]),
            .eq         (eq[i]),
            .entry      (entry[i])
        );
    end

    sset_resolve #(
        .CAPACITY (CAPACITY),
        .CW       (CW)
    ) u_resolve (
        .fire       (fire),
        .command    (in_item_reg.command),
        .eq         (eq),
        .count      (count_reg),
        .hit        (hit),
        .status     (status),
        .shift      (shift),
        .count_next (count_next)
    );

    // Build the result item
    assign count_wide = {{COUNT_W{1'b0}}, count_next};

    always_comb
    begin
        out_item_next.found  = hit;
        out_item_next.status = status;
        out_item_next.count  = count_wide[COUNT_W-1:0];
    end

    // Control registers: input/output valid and entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            count_reg <= count_next;
        end
    end

    // Payload registers: capture the item and the result
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_item_reg <= in_item;
        end
        if (fire)
        begin
            out_item_reg <= out_item_next;
        end
    end

endmodule

>>> test/tb_top.sv
// ============================================================================
// tb_top: sorted set insert / search / delete
// Drives search, insert and delete items through the valid/ready input
// channel and checks each result against its table row or a behavioral set copy.
// A directed table covers empty and full store, extremes, duplicates and the
// unused command code. Random phases then use a small value pool so that
// hits, duplicates and a full store occur often. Sender and receiver idle
// at varying rates, and the receiver holds off once to back the block up.
// ============================================================================
module tb_top;
    import sset_pkg::*;

    localparam int unsigned      SET_CAP          = 16;
    localparam int unsigned      POOL_SIZE        = 24;
    localparam int unsigned      RANDOM_PER_PHASE = 480;
    localparam int unsigned      HOLD_CYCLES      = 60;
    localparam logic [1:0]       CMD_UNUSED       = 2'd3;
    localparam logic signed [31:0] VAL_MIN        = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX        = 32'sh7FFF_FFFF;

    typedef struct {
        logic [1:0]          command;
        logic signed [31:0]  value;
        bit                  typed;
        out_item_t           result;
    } step_row_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  in_item   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_item;

    // Behavioral set contents, ascending, and the results still owed
    logic signed [31:0] set_values[$];
    out_item_t          expected_results[$];
    step_row_t          directed_steps[$];
    logic signed [31:0] value_pool[POOL_SIZE];

    int          failures      = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    bit          hold_armed    = 1'b0;
    bit          hold_done     = 1'b0;
    int unsigned hold_left     = 0;

    sorted_set_insert_search_delete_top #(
        .CAPACITY (SET_CAP)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Apply one operation to the set and return the result it should give
    function automatic out_item_t apply_set_op(in_item_t it);
        out_item_t          r;
        logic signed [31:0] v;
        int                 pos;
        bit                 hit;
        v   = it.value;
        pos = 0;
        while (pos < set_values.size() && $signed(set_values[pos]) < $signed(v))
            pos++;
        hit = (pos < set_values.size()) && (set_values[pos] == v);
        r.found = hit;
        case (it.command)
            CMD_INSERT:
            begin
                if (hit)
                    r.status = ST_DUPLICATE;
                else if (set_values.size() >= SET_CAP)
                    r.status = ST_FULL;
                else
                begin
                    set_values.insert(pos, v);
                    r.status = ST_DONE;
                end
            end
            CMD_DELETE:
            begin
                if (hit)
                begin
                    set_values.delete(pos);
                    r.status = ST_DONE;
                end
                else
                    r.status = ST_NOT_FOUND;
            end
            default:
                r.status = hit ? ST_DONE : ST_NOT_FOUND;
        endcase
        r.count = COUNT_W'(set_values.size());
        return r;
    endfunction

    function automatic void add_row(logic [1:0] command, logic signed [31:0] value,
                                    bit typed, logic found, status_t status,
                                    logic [COUNT_W-1:0] count);
        step_row_t row;
        row.command       = command;
        row.value         = value;
        row.typed         = typed;
        row.result.found  = found;
        row.result.status = status;
        row.result.count  = count;
        directed_steps.push_back(row);
    endfunction

    // Refill the value pool, mostly random with some extremes mixed in
    function automatic void refresh_pool();
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            case ($urandom_range(7))
                0:       value_pool[i] = VAL_MIN;
                1:       value_pool[i] = VAL_MAX;
                default: value_pool[i] = $urandom();
            endcase
        end
    endfunction

    function automatic in_item_t random_set_op(int unsigned insert_pct);
        in_item_t    it;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < insert_pct)
            it.command = CMD_INSERT;
        else if (pick < insert_pct + 30)
            it.command = CMD_DELETE;
        else if (pick < 95)
            it.command = CMD_SEARCH;
        else
            it.command = CMD_UNUSED;
        if ($urandom_range(9) < 8)
            it.value = value_pool[$urandom_range(POOL_SIZE - 1)];
        else
            it.value = $urandom();
        return it;
    endfunction

    // Offer one item, wait for acceptance, then record the owed result
    task automatic offer_item(in_item_t it, bit typed, out_item_t typed_result);
        out_item_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = apply_set_op(it);
        expected_results.push_back(typed ? typed_result : predicted);
    endtask

    function automatic void check_result(out_item_t got);
        out_item_t want;
        if (expected_results.size() == 0)
        begin
            $error("unexpected result item: found %0d status %0d count %0d",
                   got.found, got.status, got.count);
            failures++;
            return;
        end
        want = expected_results.pop_front();
        if (got.found !== want.found)
        begin
            $error("found: expected %0d, actual %0d", want.found, got.found);
            failures++;
        end
        if (got.status !== want.status)
        begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            failures++;
        end
        if (got.count !== want.count)
        begin
            $error("count: expected %0d, actual %0d", want.count, got.count);
            failures++;
        end
    endfunction

    // Receiver: check accepted results, then pick out_ready for the next cycle
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            check_result(out_item);
        if (hold_armed && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Stimulus
    initial
    begin
        logic signed [31:0] fill_values[12];
        in_item_t           it;
        int unsigned        insert_pct;

        fill_values = '{32'sd5, -32'sd5, 32'sd3, -32'sd100, 32'sd2000000000,
                        -32'sd2000000000, 32'sd1, 32'sd2, 32'sh5555_5555,
                        32'shAAAA_AAAA, 32'sd42, 32'sd7};

        // Empty store, extremes, duplicates and the unused code
        add_row(CMD_SEARCH, 32'sd0, 1'b1, 1'b0, ST_NOT_FOUND, 5'd0);
        add_row(CMD_DELETE, 32'sd5, 1'b1, 1'b0, ST_NOT_FOUND, 5'd0);
        add_row(CMD_INSERT, VAL_MIN, 1'b1, 1'b0, ST_DONE, 5'd1);
        add_row(CMD_INSERT, VAL_MAX, 1'b1, 1'b0, ST_DONE, 5'd2);
        add_row(CMD_INSERT, VAL_MIN, 1'b1, 1'b1, ST_DUPLICATE, 5'd2);
        add_row(CMD_INSERT, 32'sd0, 1'b1, 1'b0, ST_DONE, 5'd3);
        add_row(CMD_INSERT, -32'sd1, 1'b1, 1'b0, ST_DONE, 5'd4);
        add_row(CMD_UNUSED, -32'sd1, 1'b1, 1'b1, ST_DONE, 5'd4);
        add_row(CMD_UNUSED, 32'sd7, 1'b1, 1'b0, ST_NOT_FOUND, 5'd4);
        // Fill to capacity, then hit the full store
        for (int i = 0; i < 12; i++)
            add_row(CMD_INSERT, fill_values[i], 1'b1, 1'b0, ST_DONE, COUNT_W'(5 + i));
        add_row(CMD_INSERT, 32'sd99, 1'b1, 1'b0, ST_FULL, 5'd16);
        add_row(CMD_INSERT, 32'sd0, 1'b1, 1'b1, ST_DUPLICATE, 5'd16);
        add_row(CMD_SEARCH, 32'sh5555_5555, 1'b0, 1'b0, ST_DONE, 5'd0);
        add_row(CMD_DELETE, VAL_MIN, 1'b1, 1'b1, ST_DONE, 5'd15);
        add_row(CMD_DELETE, 32'sd99, 1'b1, 1'b0, ST_NOT_FOUND, 5'd15);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_steps[i])
        begin
            it.command = directed_steps[i].command;
            it.value   = directed_steps[i].value;
            offer_item(it, directed_steps[i].typed, directed_steps[i].result);
        end

        // Random phases: sender-light, receiver-light, then no idling
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 15;
                    recv_idle_pct <= 72;
                    insert_pct     = 55;
                end
                1:
                begin
                    send_idle_pct  = 72;
                    recv_idle_pct <= 15;
                    insert_pct     = 30;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_idle_pct <= 0;
                    hold_armed    <= 1'b1;
                    insert_pct     = 45;
                end
            endcase
            refresh_pool();
            repeat (RANDOM_PER_PHASE)
                offer_item(random_set_op(insert_pct), 1'b0, '0);
        end
        in_valid <= 1'b0;

        // Drain, then allow stray results to show up
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Hard stop if the run hangs
    initial
    begin
        #800000;
        $display("status: fail");
        $finish;
    end

endmodule
